### rtl/core/lrfc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfc_pkg
// Types, constants and the CRC-32C byte update shared by the log record
// frame checker and its parts.
// ----------------------------------------------------------------------------
package lrfc_pkg;

   localparam int unsigned HEADER_BYTES   = 16;
   localparam int unsigned SENTINEL_BYTES = 16;
   localparam int unsigned MAGIC_BYTES    = 8;
   localparam int unsigned POS_BITS       = 25;

   localparam logic [31:0] CRC_POLY = 32'h82F63B78;
   localparam logic [31:0] CRC_ONES = 32'hFFFFFFFF;

   localparam logic [23:0] LEN_SAT           = 24'hFFFFFF;
   localparam logic [23:0] MAX_PAYLOAD_RESET = 24'd1048576;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_LENGTH    = 3'd1;
   localparam logic [2:0] STATUS_SENTINEL  = 3'd2;
   localparam logic [2:0] STATUS_CRC       = 3'd3;
   localparam logic [2:0] STATUS_TRUNCATED = 3'd4;

   localparam logic [7:0] CSR_MAX_PAYLOAD    = 8'd0;
   localparam logic [7:0] CSR_SENTINEL_MAGIC = 8'd1;
   localparam logic [7:0] CSR_START_OFFSET   = 8'd2;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       has_byte;
      logic       end_of_stream;
   } lrfc_req_type;

   typedef struct packed {
      logic [47:0] event_offset;
      logic [31:0] event_type;
      logic [23:0] body_len;
      logic [2:0]  status;
      logic [47:0] good_end;
      logic        final_res;
   } lrfc_rsp_type;

   typedef struct packed {
      logic first;
      logic second;
   } lrfc_push_type;

   function automatic logic [31:0] crc32c_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
      end
      return c;
   endfunction

   function automatic logic [23:0] sat_len(input logic [31:0] v);
      return (v > {8'd0, LEN_SAT}) ? LEN_SAT : v[23:0];
   endfunction

endpackage

### rtl/core/lrfc_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfc_req_if / lrfc_rsp_if
// Valid/ready channels for the byte stream and for the result stream.
// ----------------------------------------------------------------------------
interface lrfc_req_if;
   import lrfc_pkg::*;
   logic         valid;
   logic         ready;
   lrfc_req_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface lrfc_rsp_if;
   import lrfc_pkg::*;
   logic         valid;
   logic         ready;
   lrfc_rsp_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/lrfc_record_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfc_record_engine
// Configuration registers and record parsing state; takes one byte per
// transfer and forms up to two results for it.
// ----------------------------------------------------------------------------
module lrfc_record_engine import lrfc_pkg::*; #(
   parameter int unsigned OFFSET_BITS = 48
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [7:0]    csr_index,
   input  logic [63:0]   csr_wdata,
   input  logic          accept,
   input  lrfc_req_type  item,
   output lrfc_push_type push,
   output lrfc_rsp_type  first_res,
   output lrfc_rsp_type  second_res
);

   logic [23:0]            max_payload_ff, max_payload_in;
   logic [63:0]            magic_ff, magic_in;
   logic [47:0]            start_ff, start_in;
   logic [OFFSET_BITS-1:0] rs_ff, rs_in;
   logic [OFFSET_BITS-1:0] lge_ff, lge_in;
   logic [POS_BITS-1:0]    pos_ff, pos_in;
   logic [31:0]            len_ff, len_in;
   logic [31:0]            type_ff, type_in;
   logic [31:0]            stored_ff, stored_in;
   logic [31:0]            crc_ff, crc_in;
   logic [63:0]            shift_ff, shift_in;
   logic                   bad_ff, bad_in;
   logic                   halted_ff, halted_in;

   logic [OFFSET_BITS-1:0] rec_end;
   logic [63:0]            rs_wide;
   logic [63:0]            shift_next;
   logic [32:0]            pay_end;
   logic [32:0]            sent_diff;
   logic [3:0]             sent_idx;
   logic                   take;
   logic                   byte_hit;
   logic [2:0]             byte_status;
   logic                   hdr_done;
   logic                   restart;
   lrfc_rsp_type           byte_res;
   lrfc_rsp_type           sum_res;

   assign rec_end    = rs_ff + OFFSET_BITS'(len_ff)
                     + OFFSET_BITS'(HEADER_BYTES + SENTINEL_BYTES);
   assign rs_wide    = 64'(rs_ff);
   assign shift_next = {item.data_byte, shift_ff[63:8]};
   assign pay_end    = 33'(HEADER_BYTES) + 33'(len_ff);
   assign sent_diff  = 33'(pos_ff) - pay_end;
   assign sent_idx   = sent_diff[3:0];
   assign take       = accept && item.has_byte && !halted_ff;

   always_comb begin
      max_payload_in = max_payload_ff;
      magic_in       = magic_ff;
      start_in       = start_ff;
      rs_in          = rs_ff;
      lge_in         = lge_ff;
      pos_in         = pos_ff;
      len_in         = len_ff;
      type_in        = type_ff;
      stored_in      = stored_ff;
      crc_in         = crc_ff;
      shift_in       = shift_ff;
      bad_in         = bad_ff;
      halted_in      = halted_ff;
      byte_hit       = 1'b0;
      byte_status    = STATUS_OK;
      restart        = 1'b0;

      if (take) begin
         pos_in = pos_ff + POS_BITS'(1);
         if (pos_ff < POS_BITS'(HEADER_BYTES)) begin
            case (pos_ff[3:2])
               2'd0: len_in[{pos_ff[1:0], 3'b000} +: 8] = item.data_byte;
               2'd1: type_in[{pos_ff[1:0], 3'b000} +: 8] = item.data_byte;
               2'd3: stored_in[{pos_ff[1:0], 3'b000} +: 8] = item.data_byte;
               default: ;
            endcase
            if (pos_ff == POS_BITS'(HEADER_BYTES - 1)) begin
               crc_in = CRC_ONES;
               bad_in = 1'b0;
               if (len_in > {8'd0, max_payload_ff}) begin
                  halted_in   = 1'b1;
                  byte_hit    = 1'b1;
                  byte_status = STATUS_LENGTH;
               end
            end
         end else if (33'(pos_ff) < pay_end) begin
            crc_in = crc32c_byte(crc_ff, item.data_byte);
         end else begin
            shift_in = shift_next;
            if (sent_idx == 4'(MAGIC_BYTES - 1) && shift_next != magic_ff) begin
               bad_in = 1'b1;
            end
            if (sent_idx == 4'(SENTINEL_BYTES - 1)) begin
               byte_hit = 1'b1;
               if (bad_ff || shift_next != rs_wide) begin
                  halted_in   = 1'b1;
                  byte_status = STATUS_SENTINEL;
               end else if ((crc_ff ^ CRC_ONES) != stored_ff) begin
                  halted_in   = 1'b1;
                  byte_status = STATUS_CRC;
               end else begin
                  lge_in = rec_end;
                  rs_in  = rec_end;
                  pos_in = '0;
                  crc_in = CRC_ONES;
                  bad_in = 1'b0;
               end
            end
         end
      end

      byte_res.event_offset = 48'(rs_ff);
      byte_res.event_type   = type_in;
      byte_res.body_len     = sat_len(len_in);
      byte_res.status       = byte_status;
      byte_res.good_end     = 48'(lge_in);
      byte_res.final_res    = 1'b0;

      hdr_done             = halted_in || (pos_in >= POS_BITS'(HEADER_BYTES));
      sum_res.event_offset = 48'(rs_in);
      sum_res.event_type   = hdr_done ? type_in : 32'd0;
      sum_res.body_len     = hdr_done ? sat_len(len_in) : 24'd0;
      sum_res.status       = (!halted_in && pos_in != '0) ? STATUS_TRUNCATED : STATUS_OK;
      sum_res.good_end     = 48'(lge_in);
      sum_res.final_res    = 1'b1;

      if (byte_hit) begin
         push.first  = 1'b1;
         push.second = accept && item.end_of_stream;
         first_res   = byte_res;
         second_res  = sum_res;
      end else begin
         push.first  = accept && item.end_of_stream;
         push.second = 1'b0;
         first_res   = sum_res;
         second_res  = sum_res;
      end

      if (accept && item.end_of_stream) begin
         restart = 1'b1;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_MAX_PAYLOAD:    max_payload_in = csr_wdata[23:0];
            CSR_SENTINEL_MAGIC: magic_in       = csr_wdata;
            CSR_START_OFFSET: begin
               start_in = csr_wdata[47:0];
               restart  = 1'b1;
            end
            default: ;
         endcase
      end

      if (restart) begin
         rs_in     = OFFSET_BITS'(start_in);
         lge_in    = OFFSET_BITS'(start_in);
         pos_in    = '0;
         len_in    = '0;
         type_in   = '0;
         stored_in = '0;
         crc_in    = CRC_ONES;
         shift_in  = '0;
         bad_in    = 1'b0;
         halted_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_payload_ff <= MAX_PAYLOAD_RESET;
         magic_ff       <= '0;
         start_ff       <= '0;
         rs_ff          <= '0;
         lge_ff         <= '0;
         pos_ff         <= '0;
         len_ff         <= '0;
         type_ff        <= '0;
         stored_ff      <= '0;
         crc_ff         <= CRC_ONES;
         shift_ff       <= '0;
         bad_ff         <= 1'b0;
         halted_ff      <= 1'b0;
      end else begin
         max_payload_ff <= max_payload_in;
         magic_ff       <= magic_in;
         start_ff       <= start_in;
         rs_ff          <= rs_in;
         lge_ff         <= lge_in;
         pos_ff         <= pos_in;
         len_ff         <= len_in;
         type_ff        <= type_in;
         stored_ff      <= stored_in;
         crc_ff         <= crc_in;
         shift_ff       <= shift_in;
         bad_ff         <= bad_in;
         halted_ff      <= halted_in;
      end
   end

endmodule

### rtl/core/lrfc_result_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfc_result_queue
// Four-entry result queue that takes up to two results per cycle and
// presents one per transfer on the result channel.
// ----------------------------------------------------------------------------
module lrfc_result_queue import lrfc_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  lrfc_push_type push,
   input  lrfc_rsp_type  first_res,
   input  lrfc_rsp_type  second_res,
   output logic          in_ready,
   lrfc_rsp_if.source    rsp
);

   localparam int unsigned DEPTH    = 4;
   localparam int unsigned PTR_BITS = $clog2(DEPTH);
   localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

   lrfc_rsp_type        slot_ff [DEPTH];
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic [CNT_BITS-1:0] push_cnt;
   logic                pop;

   assign pop       = rsp.valid && rsp.ready;
   assign push_cnt  = CNT_BITS'(push.first) + CNT_BITS'(push.second);
   assign rd_ptr_in = rd_ptr_ff + PTR_BITS'(pop);
   assign wr_ptr_in = wr_ptr_ff + PTR_BITS'(push_cnt);
   assign count_in  = count_ff + push_cnt - CNT_BITS'(pop);

   assign in_ready    = count_ff <= CNT_BITS'(DEPTH - 2);
   assign rsp.valid   = count_ff != '0;
   assign rsp.payload = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first) begin
         slot_ff[wr_ptr_ff] <= first_res;
      end
      if (push.second) begin
         slot_ff[wr_ptr_ff + PTR_BITS'(1)] <= second_res;
      end
   end

endmodule

### rtl/core/log_record_frame_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// log_record_frame_checker
// Checks framed log records (header, CRC-32C payload, sentinel) in a byte
// stream and reports each record and an end-of-stream summary.
// Results are registered in the result queue before they reach the result channel.
// Throughput: one byte per cycle while the result queue has room; an item
// with two results offers them on the result port one after the other, and
// the four-entry result queue takes input while at least two entries are free.
// Reset: synchronous; empties the queue, loads register defaults, starts a run.
// ----------------------------------------------------------------------------
module log_record_frame_checker import lrfc_pkg::*; #(
   parameter int unsigned OFFSET_BITS = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [7:0]  csr_index,
   input  logic [63:0] csr_wdata,
   lrfc_req_if.sink    req_if,
   lrfc_rsp_if.source  rsp_if
);

   logic          accept;
   logic          in_ready;
   lrfc_push_type push;
   lrfc_rsp_type  first_res;
   lrfc_rsp_type  second_res;

   assign req_if.ready = in_ready;
   assign accept       = req_if.valid && in_ready;

   lrfc_record_engine #(
      .OFFSET_BITS (OFFSET_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .accept     (accept),
      .item       (req_if.payload),
      .push       (push),
      .first_res  (first_res),
      .second_res (second_res)
   );

   lrfc_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .first_res  (first_res),
      .second_res (second_res),
      .in_ready   (in_ready),
      .rsp        (rsp_if)
   );

endmodule

### rtl/core/lrfc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrfc_checker
// Port-level assertions for the log record frame checker.
// ----------------------------------------------------------------------------
module lrfc_checker import lrfc_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input lrfc_rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while a transfer was stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered straight after reset");

   a_offset_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status != STATUS_OK
      |-> rsp_payload.event_offset == rsp_payload.good_end)
      else $error("failed record does not start at the last good end");

   a_trunc_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_TRUNCATED |-> rsp_payload.final_res)
      else $error("truncated status outside the summary");

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status <= STATUS_TRUNCATED)
      else $error("undefined status code");

endmodule

bind log_record_frame_checker lrfc_checker u_lrfc_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_if.valid),
   .rsp_ready   (rsp_if.ready),
   .rsp_payload (rsp_if.payload)
);
